### design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Item types, opcodes and character codes of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_SETC  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_BLANK = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h00;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [4:0] row_sel;
    logic [6:0] col_sel;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_index;
    logic [7:0]  read_char;
    logic        scrolled;
  } out_item_t;

endpackage

`default_nettype wire

### design/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Teletype engine over a ROWS x COLUMNS character store with a cursor.
// ----------------------------------------------------------------------------
// Steps: put EXEC, CHAR, DONE (EXEC, DONE for an ignored byte; a pending wrap at
//   the last row scrolls first), read EXEC, RDWAIT, DONE (EXEC, DONE out of range),
//   set cursor EXEC, DONE; scroll walks every cell then DRAIN, clear every cell.
// Throughput: one item at a time; the next item is taken once the result is
//   in the output register. The single store write port and the sequencer set this.
// Reset: cursor to 0,0, then a fill pass writes spaces to every cell; no item
//   is accepted until it ends.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS + 1);   // column may sit at COLUMNS
  localparam int MAW   = $clog2(CELLS);
  localparam int AW    = $clog2(CELLS + 1);     // cursor index may reach CELLS

  localparam logic [RW-1:0]  ROW_LAST  = RW'(ROWS - 1);
  localparam logic [CW-1:0]  COL_END   = CW'(COLUMNS);
  localparam logic [CW-1:0]  COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [MAW-1:0] CELL_LAST = MAW'(CELLS - 1);
  localparam logic [MAW-1:0] COPY_LAST = MAW'(CELLS - COLUMNS - 1);

  // sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_EXEC   = 4'd1;  // decode, resolve pending wrap
  localparam logic [3:0] ST_CHAR   = 4'd2;  // handle the put byte
  localparam logic [3:0] ST_RDWAIT = 4'd3;  // store read data lands
  localparam logic [3:0] ST_SCROLL = 4'd4;  // copy rows up, zero last row
  localparam logic [3:0] ST_DRAIN  = 4'd5;  // last scroll write
  localparam logic [3:0] ST_CLEAR  = 4'd6;  // fill with spaces
  localparam logic [3:0] ST_DONE   = 4'd7;  // load output register

  logic [3:0]     state_r, state_nxt;
  logic [3:0]     ret_r, ret_nxt;       // where a scroll returns to
  logic           init_r, init_nxt;     // fill pass after reset
  logic [RW-1:0]  row_r, row_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic           sc_r, sc_nxt;
  logic [7:0]     rd_r, rd_nxt;
  logic [MAW-1:0] cnt_r, cnt_nxt;
  logic           pend_r, pend_nxt;     // scroll write in flight
  logic           pend_zero_r, pend_zero_nxt;
  logic [MAW-1:0] pend_addr_r, pend_addr_nxt;
  logic           out_valid_r, out_valid_nxt;
  in_item_t       in_r;
  out_item_t      out_r;

  // shared address unit
  logic [RW-1:0]  au_row;
  logic [CW-1:0]  au_col;
  logic [AW-1:0]  au_addr;

  // store port
  logic           mem_we;
  logic [MAW-1:0] mem_waddr;
  logic [7:0]     mem_wdata;
  logic [MAW-1:0] mem_raddr;
  logic [7:0]     mem_rdata;

  logic           in_acc;
  logic           out_load;
  logic           sel_ok;
  logic           is_bs;
  logic [AW-1:0]  copy_src;

  tcw_addr_unit #(
    .COLUMNS (COLUMNS),
    .RW      (RW),
    .CW      (CW),
    .AW      (AW)
  ) u_addr (
    .row  (au_row),
    .col  (au_col),
    .addr (au_addr)
  );

  tcw_screen_mem #(
    .DEPTH (CELLS),
    .AW    (MAW),
    .DW    (8)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  assign is_bs    = (in_r.char_code == CH_BS);
  assign sel_ok   = (32'(in_r.row_sel) < ROWS) && (32'(in_r.col_sel) < COLUMNS);
  assign copy_src = AW'(cnt_r) + AW'(COLUMNS);

  // address unit operand select: selected cell on a read, cursor (or the
  // cell left of it for backspace) otherwise
  always_comb begin
    au_row = row_r;
    au_col = col_r;
    if (state_r == ST_EXEC) begin
      au_row = RW'(in_r.row_sel);
      au_col = CW'(in_r.col_sel);
    end else if (state_r == ST_CHAR && is_bs) begin
      au_col = col_r - CW'(1);
    end
  end

  // store port select; a pending scroll write always wins
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = MAW'(au_addr);
    mem_wdata = in_r.char_code;
    mem_raddr = MAW'(au_addr);
    if (state_r == ST_SCROLL) begin
      mem_raddr = MAW'(copy_src);
    end
    if (pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_r;
      mem_wdata = pend_zero_r ? CH_ZERO : mem_rdata;
    end else if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_r;
      mem_wdata = CH_BLANK;
    end else if (state_r == ST_CHAR && in_r.char_code != CH_LF) begin
      if (is_bs) begin
        mem_we    = (col_r != '0);
        mem_wdata = CH_BLANK;
      end else begin
        mem_we    = 1'b1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    init_nxt      = init_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    sc_nxt        = sc_r;
    rd_nxt        = rd_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    pend_zero_nxt = pend_zero_r;
    pend_addr_nxt = pend_addr_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sc_nxt    = 1'b0;
          rd_nxt    = '0;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (in_r.opcode)
          OP_PUT: begin
            if (in_r.char_code == CH_NUL || in_r.char_code == CH_CR) begin
              state_nxt = ST_DONE;
            end else if (col_r >= COL_END) begin
              // pending wrap: next line or scroll, then the byte
              col_nxt = '0;
              if (row_r >= ROW_LAST) begin
                row_nxt   = ROW_LAST;
                sc_nxt    = 1'b1;
                cnt_nxt   = '0;
                ret_nxt   = ST_CHAR;
                state_nxt = ST_SCROLL;
              end else begin
                row_nxt   = row_r + RW'(1);
                state_nxt = ST_CHAR;
              end
            end else begin
              state_nxt = ST_CHAR;
            end
          end
          OP_READ: begin
            state_nxt = sel_ok ? ST_RDWAIT : ST_DONE;
          end
          OP_SETC: begin
            row_nxt   = (32'(in_r.row_sel) < ROWS) ? RW'(in_r.row_sel) : ROW_LAST;
            col_nxt   = (32'(in_r.col_sel) < COLUMNS) ? CW'(in_r.col_sel) : COL_LAST;
            state_nxt = ST_DONE;
          end
          OP_CLEAR: begin
            row_nxt   = '0;
            col_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_CLEAR;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_CHAR: begin
        state_nxt = ST_DONE;
        if (in_r.char_code == CH_LF) begin
          col_nxt = '0;
          if (row_r >= ROW_LAST) begin
            row_nxt   = ROW_LAST;
            sc_nxt    = 1'b1;
            cnt_nxt   = '0;
            ret_nxt   = ST_DONE;
            state_nxt = ST_SCROLL;
          end else begin
            row_nxt = row_r + RW'(1);
          end
        end else if (is_bs) begin
          if (col_r != '0) begin
            col_nxt = col_r - CW'(1);
          end
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
      ST_RDWAIT: begin
        rd_nxt    = mem_rdata;
        state_nxt = ST_DONE;
      end
      ST_SCROLL: begin
        // issue one cell a cycle: copy from the row below, then zero fill
        pend_nxt      = 1'b1;
        pend_addr_nxt = cnt_r;
        pend_zero_nxt = (cnt_r > COPY_LAST);
        if (cnt_r == CELL_LAST) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + MAW'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ret_r;
      end
      ST_CLEAR: begin
        if (cnt_r == CELL_LAST) begin
          init_nxt  = 1'b0;
          state_nxt = init_r ? ST_IDLE : ST_DONE;
        end else begin
          cnt_nxt = cnt_r + MAW'(1);
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ret_r       <= ST_DONE;
      init_r      <= 1'b1;
      row_r       <= '0;
      col_r       <= '0;
      sc_r        <= 1'b0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      init_r      <= init_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      sc_r        <= sc_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_r        <= rd_nxt;
    pend_zero_r <= pend_zero_nxt;
    pend_addr_r <= pend_addr_nxt;
    if (in_acc) begin
      in_r <= in_data;
    end
    if (out_load) begin
      out_r.cursor_row   <= 5'(row_r);
      out_r.cursor_col   <= 7'(col_r);
      out_r.cursor_index <= 11'(au_addr);
      out_r.read_char    <= rd_r;
      out_r.scrolled     <= sc_r;
    end
  end

endmodule

`default_nettype wire

### design/tcw_addr_unit.sv
// ----------------------------------------------------------------------------
// tcw_addr_unit
// Shared linear address unit: row * COLUMNS + column.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_addr_unit #(
  parameter int COLUMNS = 80,
  parameter int RW      = 5,
  parameter int CW      = 7,
  parameter int AW      = 11
) (
  input  wire logic [RW-1:0] row,
  input  wire logic [CW-1:0] col,
  output logic      [AW-1:0] addr
);

  // constant multiply, folds to shifts and adds
  assign addr = AW'(row) * AW'(COLUMNS) + AW'(col);

endmodule

`default_nettype wire

### design/tcw_screen_mem.sv
// ----------------------------------------------------------------------------
// tcw_screen_mem
// Character store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_screen_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
